/* rtl/core/octn_pkg.sv */
package octn_pkg;

	// default widths of the component inputs and of the codes
	localparam int unsigned COMPONENT_BITS_DEF = 16;
	localparam int unsigned CODE_BITS_DEF      = 16;

endpackage

/* rtl/core/octn_if.sv */
interface octn_normal_if #(
	parameter int unsigned CW = octn_pkg::COMPONENT_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] normal_x;
	logic signed [CW-1:0] normal_y;
	logic signed [CW-1:0] normal_z;

	modport source (output valid, output normal_x, output normal_y, output normal_z,
		input ready);
	modport sink (input valid, input normal_x, input normal_y, input normal_z,
		output ready);
endinterface

interface octn_code_if #(
	parameter int unsigned KW = octn_pkg::CODE_BITS_DEF
) ();
	logic          valid;
	logic          ready;
	logic [KW-1:0] code_x;
	logic [KW-1:0] code_y;
	logic          zero_vector;

	modport source (output valid, output code_x, output code_y, output zero_vector,
		input ready);
	modport sink (input valid, input code_x, input code_y, input zero_vector,
		output ready);
endinterface

/* rtl/core/octahedral_normal_encoder_core.sv */
// octahedral normal encoder
// normals (sink): valid/ready beat carrying normal_x, normal_y, normal_z as
// signed COMPONENT_BITS-bit values of one common scale.
// codes (source): valid/ready beat carrying code_x, code_y (CODE_BITS bits,
// 0 .. 2^CODE_BITS-1) and zero_vector; an all-zero normal gives
// zero_vector = 1 and both codes at 2^(CODE_BITS-1).
// one result beat per input beat, in order.
// the pipeline has three stages for abs/sum, fold and clamp, and the scaled
// dividend, then one restoring-division stage per code bit.
// throughput is one beat per cycle while no result is stalled; every
// stage is a register stage.
// when codes.ready is low with a result waiting, the whole pipeline holds
// and normals.ready drops; nothing is lost or repeated.
// reset clears all valid bits; the block takes a beat in the first cycle
// after reset is released.
module octahedral_normal_encoder_core #(
	parameter int unsigned COMPONENT_BITS = octn_pkg::COMPONENT_BITS_DEF,
	parameter int unsigned CODE_BITS      = octn_pkg::CODE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	octn_normal_if.sink   normals,
	octn_code_if.source   codes
);
	localparam int unsigned DW = COMPONENT_BITS + 2;
	localparam logic [CODE_BITS-1:0] MID = {1'b1, {(CODE_BITS-1){1'b0}}};

	logic                  en;
	logic                  f_valid, f_zero;
	logic [DW+CODE_BITS-1:0] f_num_x, f_num_y;
	logic [DW-1:0]         f_den;
	logic                  d_valid, d_zero;
	logic [CODE_BITS-1:0]  d_q_x, d_q_y;

	// pipeline advances unless a result waits on a stalled receiver
	assign en            = !d_valid || codes.ready;
	assign normals.ready = en;

	octn_front #(
		.CW (COMPONENT_BITS),
		.K  (CODE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (normals.valid),
		.normal_x  (normals.normal_x),
		.normal_y  (normals.normal_y),
		.normal_z  (normals.normal_z),
		.out_valid (f_valid),
		.num_x     (f_num_x),
		.num_y     (f_num_y),
		.den       (f_den),
		.zero      (f_zero)
	);

	octn_div #(
		.DW (DW),
		.K  (CODE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.num_x     (f_num_x),
		.num_y     (f_num_y),
		.den       (f_den),
		.zero_in   (f_zero),
		.out_valid (d_valid),
		.q_x       (d_q_x),
		.q_y       (d_q_y),
		.zero_out  (d_zero)
	);

	assign codes.valid       = d_valid;
	assign codes.code_x      = d_zero ? MID : d_q_x;
	assign codes.code_y      = d_zero ? MID : d_q_y;
	assign codes.zero_vector = d_zero;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(codes.valid && !codes.ready) |=> codes.valid && $stable(d_q_x) && $stable(d_zero))
		else $error("stalled result changed inside pipeline");
endmodule

/* rtl/core/octn_front.sv */
module octn_front #(
	parameter int unsigned CW = octn_pkg::COMPONENT_BITS_DEF,
	parameter int unsigned K  = octn_pkg::CODE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] normal_x,
	input  logic signed [CW-1:0] normal_y,
	input  logic signed [CW-1:0] normal_z,
	output logic                 out_valid,
	output logic [CW+K+1:0]      num_x,
	output logic [CW+K+1:0]      num_y,
	output logic [CW+1:0]        den,
	output logic                 zero
);
	localparam int unsigned SW = CW + 1;
	localparam int unsigned DW = CW + 2;
	localparam int unsigned FW = CW + 3;
	localparam int unsigned NW = DW + K;

	// fold by max(0,-z), clamp to [-s,s], then shift up by s
	function automatic logic [DW-1:0] fold(input logic signed [CW-1:0] c,
		input logic [CW-1:0] t, input logic [SW-1:0] s);
		logic signed [FW-1:0] cw;
		logic signed [FW-1:0] tw;
		logic signed [FW-1:0] sw;
		logic signed [FW-1:0] n;
		cw = FW'(c);
		tw = signed'(FW'(t));
		sw = signed'(FW'(s));
		n  = (cw >= 0) ? cw + tw : cw - tw;
		if (n > sw) n = sw;
		if (n < -sw) n = -sw;
		n = n + sw;
		return n[DW-1:0];
	endfunction

	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [CW-1:0] x_s1, y_s1;
	logic [CW-1:0]        t_s1;
	logic [SW-1:0]        s_s1, s_s2;
	logic                 zero_s1, zero_s2, zero_s3;
	logic [DW-1:0]        a_x_s2, a_y_s2, d_s3;
	logic [NW-1:0]        num_x_s3, num_y_s3;

	logic [CW-1:0] xu, yu, zu, abs_x, abs_y, abs_z, t_c;
	logic [SW-1:0] sum_c;

	always_comb begin
		xu    = normal_x;
		yu    = normal_y;
		zu    = normal_z;
		abs_x = xu[CW-1] ? (~xu + 1'b1) : xu;
		abs_y = yu[CW-1] ? (~yu + 1'b1) : yu;
		abs_z = zu[CW-1] ? (~zu + 1'b1) : zu;
		t_c   = zu[CW-1] ? abs_z : '0;
		sum_c = SW'(abs_x) + SW'(abs_y) + SW'(abs_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= normal_x;
			y_s1     <= normal_y;
			t_s1     <= t_c;
			s_s1     <= sum_c;
			zero_s1  <= (xu == '0) && (yu == '0) && (zu == '0);
			a_x_s2   <= fold(x_s1, t_s1, s_s1);
			a_y_s2   <= fold(y_s1, t_s1, s_s1);
			s_s2     <= s_s1;
			zero_s2  <= zero_s1;
			// (a << K) - a is a * (2^K - 1)
			num_x_s3 <= (NW'(a_x_s2) << K) - NW'(a_x_s2) + NW'(s_s2);
			num_y_s3 <= (NW'(a_y_s2) << K) - NW'(a_y_s2) + NW'(s_s2);
			d_s3     <= {s_s2, 1'b0};
			zero_s3  <= zero_s2;
		end
	end

	assign out_valid = vld_s3;
	assign num_x     = num_x_s3;
	assign num_y     = num_y_s3;
	assign den       = d_s3;
	assign zero      = zero_s3;

	a_fold_x: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> a_x_s2 <= {s_s2, 1'b0})
		else $error("folded x exceeds 2s");
	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !zero_s3) |-> (num_x_s3 < {d_s3, {K{1'b0}}}) &&
			(num_y_s3 < {d_s3, {K{1'b0}}}))
		else $error("dividend too large for quotient width");
endmodule

/* rtl/core/octn_div.sv */
module octn_div #(
	parameter int unsigned DW = octn_pkg::COMPONENT_BITS_DEF + 2,
	parameter int unsigned K  = octn_pkg::CODE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DW+K-1:0]  num_x,
	input  logic [DW+K-1:0]  num_y,
	input  logic [DW-1:0]    den,
	input  logic             zero_in,
	output logic             out_valid,
	output logic [K-1:0]     q_x,
	output logic [K-1:0]     q_y,
	output logic             zero_out
);
	// one quotient bit per stage, restoring
	logic [DW-1:0] rem_x_sd  [K+1];
	logic [DW-1:0] rem_y_sd  [K+1];
	logic [K-1:0]  low_x_sd  [K+1];
	logic [K-1:0]  low_y_sd  [K+1];
	logic [K-1:0]  q_x_sd    [K+1];
	logic [K-1:0]  q_y_sd    [K+1];
	logic [DW-1:0] d_sd      [K+1];
	logic          zero_sd   [K+1];
	logic          vld_sd    [K+1];

	assign rem_x_sd[0] = num_x[DW+K-1:K];
	assign rem_y_sd[0] = num_y[DW+K-1:K];
	assign low_x_sd[0] = num_x[K-1:0];
	assign low_y_sd[0] = num_y[K-1:0];
	assign q_x_sd[0]   = '0;
	assign q_y_sd[0]   = '0;
	assign d_sd[0]     = den;
	assign zero_sd[0]  = zero_in;
	assign vld_sd[0]   = in_valid;

	for (genvar k = 0; k < K; k++) begin : g_step
		logic [DW:0] tr_x, tr_y, df_x, df_y;
		logic        ge_x, ge_y;

		always_comb begin
			tr_x = {rem_x_sd[k], low_x_sd[k][K-1]};
			tr_y = {rem_y_sd[k], low_y_sd[k][K-1]};
			df_x = tr_x - {1'b0, d_sd[k]};
			df_y = tr_y - {1'b0, d_sd[k]};
			ge_x = tr_x >= {1'b0, d_sd[k]};
			ge_y = tr_y >= {1'b0, d_sd[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else if (en) begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_x_sd[k+1] <= ge_x ? df_x[DW-1:0] : tr_x[DW-1:0];
				rem_y_sd[k+1] <= ge_y ? df_y[DW-1:0] : tr_y[DW-1:0];
				low_x_sd[k+1] <= {low_x_sd[k][K-2:0], 1'b0};
				low_y_sd[k+1] <= {low_y_sd[k][K-2:0], 1'b0};
				q_x_sd[k+1]   <= {q_x_sd[k][K-2:0], ge_x};
				q_y_sd[k+1]   <= {q_y_sd[k][K-2:0], ge_y};
				d_sd[k+1]     <= d_sd[k];
				zero_sd[k+1]  <= zero_sd[k];
			end
		end
	end

	assign out_valid = vld_sd[K];
	assign q_x       = q_x_sd[K];
	assign q_y       = q_y_sd[K];
	assign zero_out  = zero_sd[K];

	for (genvar k = 1; k <= K; k++) begin : g_chk
		a_rem: assert property (@(posedge clk) disable iff (!arst_n)
			(vld_sd[k] && !zero_sd[k]) |->
				(rem_x_sd[k] < d_sd[k]) && (rem_y_sd[k] < d_sd[k]))
			else $error("partial remainder not below divisor");
	end

	a_den_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sd[K] && !zero_sd[K]) |-> d_sd[K] != '0)
		else $error("nonzero vector reached output with zero divisor");
endmodule

/* verif/tb.sv */
module tb;

	localparam int unsigned CW = octn_pkg::COMPONENT_BITS_DEF;
	localparam int unsigned KW = octn_pkg::CODE_BITS_DEF;
	localparam int RANDOM_BEATS = 1800;
	localparam int CALM_FIRST = 700;
	localparam int CALM_LAST = 1000;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 3 + KW + 20;

	typedef logic signed [CW-1:0] comp_t;

	typedef struct packed {
		logic [KW-1:0] code_x;
		logic [KW-1:0] code_y;
		logic          zero_vector;
	} code_beat_t;

	class code_ledger;
		code_beat_t codes_due[$];
		int errors = 0;

		function longint fold_code(longint c, longint t, longint s);
			longint n;
			longint m;
			m = (longint'(1) << KW) - 1;
			n = (c >= 0) ? c + t : c - t;
			if (n > s)
				n = s;
			if (n < -s)
				n = -s;
			return ((n + s) * m + s) / (2 * s);
		endfunction

		function code_beat_t encode_normal(comp_t x, comp_t y, comp_t z);
			code_beat_t r;
			longint sx;
			longint sy;
			longint sz;
			longint s;
			longint t;
			sx = x;
			sy = y;
			sz = z;
			s = (sx < 0 ? -sx : sx) + (sy < 0 ? -sy : sy) + (sz < 0 ? -sz : sz);
			if (s == 0) begin
				r.code_x = KW'(longint'(1) << (KW - 1));
				r.code_y = KW'(longint'(1) << (KW - 1));
				r.zero_vector = 1'b1;
			end else begin
				t = (sz < 0) ? -sz : 0;
				r.code_x = KW'(fold_code(sx, t, s));
				r.code_y = KW'(fold_code(sy, t, s));
				r.zero_vector = 1'b0;
			end
			return r;
		endfunction

		function void note_normal(comp_t x, comp_t y, comp_t z);
			codes_due.push_back(encode_normal(x, y, z));
		endfunction

		function void check_code(code_beat_t got);
			code_beat_t want;
			if (codes_due.size() == 0) begin
				$error("code beat with nothing pending: code_x %0d code_y %0d zero_vector %0d",
					got.code_x, got.code_y, got.zero_vector);
				errors++;
				return;
			end
			want = codes_due.pop_front();
			if (got.code_x !== want.code_x) begin
				$error("code_x expected %0d got %0d", want.code_x, got.code_x);
				errors++;
			end
			if (got.code_y !== want.code_y) begin
				$error("code_y expected %0d got %0d", want.code_y, got.code_y);
				errors++;
			end
			if (got.zero_vector !== want.zero_vector) begin
				$error("zero_vector expected %0d got %0d", want.zero_vector, got.zero_vector);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic calm;
	int quiet_cycles;

	octn_normal_if #(.CW(CW)) nrm ();
	octn_code_if #(.KW(KW)) cod ();

	code_ledger ledger = new;

	octahedral_normal_encoder_core #(
		.COMPONENT_BITS(CW),
		.CODE_BITS(KW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.normals(nrm),
		.codes(cod)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		quiet_cycles = 0;
		nrm.valid = 1'b0;
		nrm.normal_x = '0;
		nrm.normal_y = '0;
		nrm.normal_z = '0;
		cod.ready = 1'b0;
	end

	// receiver stalls about one cycle in five outside the calm stretch
	always @(posedge clk)
		cod.ready <= calm || ($urandom_range(99) >= 20);

	always @(posedge clk) begin
		if (nrm.valid && nrm.ready)
			ledger.note_normal(nrm.normal_x, nrm.normal_y, nrm.normal_z);
		if (cod.valid && cod.ready)
			ledger.check_code({cod.code_x, cod.code_y, cod.zero_vector});
		if ((nrm.valid && nrm.ready) || (cod.valid && cod.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_normal(comp_t x, comp_t y, comp_t z, bit may_idle);
		int gap;
		if (may_idle && $urandom_range(99) < 10) begin
			gap = $urandom_range(4, 1);
			nrm.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		nrm.valid <= 1'b1;
		nrm.normal_x <= x;
		nrm.normal_y <= y;
		nrm.normal_z <= z;
		do
			@(posedge clk);
		while (!nrm.ready);
	endtask

	task automatic make_normal(output comp_t x, output comp_t y, output comp_t z);
		int pick;
		int corner[6] = '{-32768, -32767, -1, 0, 1, 32767};
		pick = $urandom_range(99);
		if (pick < 40) begin
			x = comp_t'($urandom);
			y = comp_t'($urandom);
			z = comp_t'($urandom);
		end else if (pick < 60) begin
			x = comp_t'(int'($urandom_range(8)) - 4);
			y = comp_t'(int'($urandom_range(8)) - 4);
			z = comp_t'(int'($urandom_range(8)) - 4);
		end else if (pick < 75) begin
			// lower hemisphere with a zero component, exercises the fold sign
			x = comp_t'($urandom);
			y = comp_t'($urandom);
			if ($urandom_range(1))
				x = '0;
			else
				y = '0;
			z = comp_t'(-int'($urandom_range(32768, 1)));
		end else if (pick < 88) begin
			x = comp_t'(corner[$urandom_range(5)]);
			y = comp_t'(corner[$urandom_range(5)]);
			z = comp_t'(corner[$urandom_range(5)]);
		end else if (pick < 95) begin
			x = comp_t'(int'($urandom_range(2000)) - 1000);
			y = comp_t'(int'($urandom_range(2000)) - 1000);
			z = comp_t'(int'($urandom_range(2000)) - 1000);
		end else begin
			x = '0;
			y = '0;
			z = '0;
		end
	endtask

	initial begin
		comp_t x;
		comp_t y;
		comp_t z;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_normal(0, 0, 0, 1'b0);
		send_normal(32767, 0, 0, 1'b0);
		send_normal(-32768, 0, 0, 1'b0);
		send_normal(0, 32767, 0, 1'b0);
		send_normal(0, -32768, 0, 1'b0);
		send_normal(0, 0, 32767, 1'b0);
		send_normal(0, 0, -32768, 1'b0);
		send_normal(-32768, -32768, -32768, 1'b1);
		send_normal(32767, 32767, 32767, 1'b1);
		send_normal(32767, -32768, -32768, 1'b0);
		send_normal(1, 0, 0, 1'b0);
		send_normal(-1, 0, 0, 1'b0);
		send_normal(0, 0, -1, 1'b0);
		send_normal(0, 5, -3, 1'b1);
		send_normal(0, -5, -3, 1'b0);
		send_normal(-1, 0, -1, 1'b0);
		send_normal(1, 1, 0, 1'b0);
		send_normal(-1, -1, 0, 1'b1);
		send_normal(100, -100, -100, 1'b0);
		send_normal(0, 0, 0, 1'b0);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			calm <= (i >= CALM_FIRST && i < CALM_LAST);
			make_normal(x, y, z);
			send_normal(x, y, z, !(i >= CALM_FIRST && i < CALM_LAST));
		end
		nrm.valid <= 1'b0;

		while (ledger.codes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
